// File: design/hlt_pkg.sv
// ----------------------------------------------------------------------------
// hlt_pkg
// Shared types and constants for the heartbeat liveness table.
// ----------------------------------------------------------------------------
package hlt_pkg;

	localparam int DEFAULT_MAX_SLOTS = 32;

	// field widths
	localparam int FUNC_W   = 2;
	localparam int SLOT_W   = 8;
	localparam int SEQ_W    = 64;
	localparam int GEN_W    = 32;
	localparam int TIME_W   = 32;
	localparam int EV_W     = 2;
	localparam int NCNT_W   = 6;
	localparam int OWN_W    = 5;
	localparam int DEATH_W  = 20;
	localparam int CFG_A_W  = 2;
	localparam int CFG_D_W  = 20;
	localparam int STAT_W   = 2;

	// stream payload layout
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 48;
	localparam int IN_RDOK_B  = 8;
	localparam int IN_ACT_B   = 9;
	localparam int IN_SEQ_LO  = 10;
	localparam int IN_GEN_LO  = 74;
	localparam int OUT_SLOT_LO = 1;
	localparam int OUT_GEN_LO  = 9;
	localparam int OUT_USED_W  = 41;

	// item kinds
	localparam logic [FUNC_W-1:0] FUNC_OBS   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

	// result kinds
	localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
	localparam logic [EV_W-1:0] EV_ALIVE = 2'd1;
	localparam logic [EV_W-1:0] EV_DEAD  = 2'd2;
	localparam logic [EV_W-1:0] EV_QUERY = 2'd3;

	// peer status
	localparam logic [STAT_W-1:0] PST_UNKNOWN = 2'd0;
	localparam logic [STAT_W-1:0] PST_ACTIVE  = 2'd1;
	localparam logic [STAT_W-1:0] PST_DEAD    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_A_W-1:0] CFG_NODE_COUNT  = 2'd0;
	localparam logic [CFG_A_W-1:0] CFG_OWN_SLOT    = 2'd1;
	localparam logic [CFG_A_W-1:0] CFG_DEATH_TICKS = 2'd2;

	localparam int BEAT_PERIOD = 2000;
	localparam int MISS_FACTOR = 4;

	localparam logic [NCNT_W-1:0]  NODE_COUNT_RST  = 6'd32;
	localparam logic [OWN_W-1:0]   OWN_SLOT_RST    = 5'd0;
	localparam logic [DEATH_W-1:0] DEATH_TICKS_RST = DEATH_W'(BEAT_PERIOD * MISS_FACTOR);

	// controller to datapath commands
	typedef struct packed {
		logic load;   // capture item, launch table read
		logic prep;   // table data valid, precompute deadline base
		logic eval;   // update table, load output register
	} hlt_cmd_t;

endpackage

// File: design/hlt_ctrl.sv
// ----------------------------------------------------------------------------
// hlt_ctrl
// Sequencer: accept, table read, evaluate; owns the output valid flag.
// ----------------------------------------------------------------------------
module hlt_ctrl
	import hlt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output hlt_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_vld_q;
	logic       out_free;

	assign out_free = !out_vld_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_vld_q;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.prep = 1'b0;
		cmd.eval = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				cmd.prep = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) begin
					cmd.eval = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.eval)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

endmodule

// File: design/hlt_dp.sv
// ----------------------------------------------------------------------------
// hlt_dp
// Datapath: config registers, peer table, tick counter, output register.
// ----------------------------------------------------------------------------
module hlt_dp
	import hlt_pkg::*;
#(
	parameter int MAX_SLOTS = DEFAULT_MAX_SLOTS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hlt_cmd_t               cmd,
	input  logic [FUNC_W-1:0]      in_func,
	input  logic [IN_DATA_W-1:0]   in_data,
	input  logic                   cfg_wen,
	input  logic [CFG_A_W-1:0]     cfg_addr,
	input  logic [CFG_D_W-1:0]     cfg_wdata,
	output logic [EV_W-1:0]        out_event,
	output logic [OUT_DATA_W-1:0]  out_data
);

	localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	// configuration
	logic [NCNT_W-1:0]  node_count_q;
	logic [OWN_W-1:0]   own_slot_q;
	logic [DEATH_W-1:0] death_ticks_q;

	// captured item
	logic [FUNC_W-1:0] func_q;
	logic [SLOT_W-1:0] slot_q;
	logic              rd_ok_q;
	logic              act_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [GEN_W-1:0]  gen_q;

	// peer table: flags in flops, payload in memory
	logic              seen_q   [MAX_SLOTS];
	logic [STAT_W-1:0] status_q [MAX_SLOTS];
	logic [SEQ_W-1:0]  seq_mem  [MAX_SLOTS];
	logic [GEN_W-1:0]  gen_mem  [MAX_SLOTS];
	logic [TIME_W-1:0] lc_mem   [MAX_SLOTS];
	logic [SEQ_W-1:0]  seq_rd_q;
	logic [GEN_W-1:0]  gen_rd_q;
	logic [TIME_W-1:0] lc_rd_q;

	logic [TIME_W-1:0] time_q;
	logic [TIME_W-1:0] tbase_q;   // time_now - death_ticks

	// output register
	logic [EV_W-1:0]   ev_q;
	logic              alive_q;
	logic [SLOT_W-1:0] eslot_q;
	logic [GEN_W-1:0]  egen_q;

	logic [IDX_W-1:0]  rd_idx;
	logic [IDX_W-1:0]  idx;
	logic              in_rng;
	logic              is_own;
	logic              obs_ok;
	logic [TIME_W-1:0] tdiff;
	logic              past;
	logic              seen_rd;
	logic [STAT_W-1:0] status_rd;

	logic [EV_W-1:0]   ev_d;
	logic              alive_d;
	logic [SLOT_W-1:0] eslot_d;
	logic [GEN_W-1:0]  egen_d;
	logic              seen_wr;
	logic              seen_val;
	logic              st_wr;
	logic [STAT_W-1:0] st_val;
	logic              mem_wr;

	assign rd_idx    = in_data[IDX_W-1:0];
	assign idx       = slot_q[IDX_W-1:0];
	assign seen_rd   = seen_q[idx];
	assign status_rd = status_q[idx];

	assign in_rng = (slot_q < {2'b00, node_count_q}) &&
	                ({1'b0, slot_q} < 9'(MAX_SLOTS));
	assign is_own = (slot_q == {3'b000, own_slot_q});
	assign obs_ok = in_rng && !is_own && rd_ok_q;

	// wrap-safe: strictly after deadline when difference is positive
	assign tdiff = tbase_q - lc_rd_q;
	assign past  = (tdiff != '0) && !tdiff[TIME_W-1];

	always_comb begin
		ev_d     = EV_NONE;
		alive_d  = 1'b0;
		eslot_d  = '0;
		egen_d   = '0;
		seen_wr  = 1'b0;
		seen_val = 1'b0;
		st_wr    = 1'b0;
		st_val   = status_rd;
		mem_wr   = 1'b0;
		case (func_q)
			FUNC_OBS: begin
				if (obs_ok) begin
					if (!act_q || (seq_q == '0)) begin
						seen_wr  = 1'b1;
						seen_val = 1'b0;
					end else if (!seen_rd || (seq_q != seq_rd_q) || (gen_q != gen_rd_q)) begin
						seen_wr  = 1'b1;
						seen_val = 1'b1;
						mem_wr   = 1'b1;
						if (status_rd != PST_ACTIVE) begin
							st_wr   = 1'b1;
							st_val  = PST_ACTIVE;
							ev_d    = EV_ALIVE;
							eslot_d = slot_q;
							egen_d  = gen_q;
						end
					end else if ((status_rd == PST_ACTIVE) && past) begin
						st_wr   = 1'b1;
						st_val  = PST_DEAD;
						ev_d    = EV_DEAD;
						eslot_d = slot_q;
						egen_d  = gen_rd_q;
					end
				end
			end
			FUNC_QUERY: begin
				ev_d    = EV_QUERY;
				eslot_d = slot_q;
				if (in_rng) begin
					if (is_own) begin
						alive_d = 1'b1;
					end else begin
						egen_d  = gen_rd_q;
						alive_d = (status_rd == PST_ACTIVE) && (gen_rd_q == gen_q) && !past;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q  <= NODE_COUNT_RST;
			own_slot_q    <= OWN_SLOT_RST;
			death_ticks_q <= DEATH_TICKS_RST;
		end else if (cfg_wen) begin
			case (cfg_addr)
				CFG_NODE_COUNT:  node_count_q  <= cfg_wdata[NCNT_W-1:0];
				CFG_OWN_SLOT:    own_slot_q    <= cfg_wdata[OWN_W-1:0];
				CFG_DEATH_TICKS: death_ticks_q <= cfg_wdata[DEATH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				seen_q[i]   <= 1'b0;
				status_q[i] <= PST_UNKNOWN;
			end
		end else if (cmd.eval) begin
			if (func_q == FUNC_TICK)
				time_q <= time_q + 1'b1;
			if (seen_wr)
				seen_q[idx] <= seen_val;
			if (st_wr)
				status_q[idx] <= st_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= in_func;
			slot_q   <= in_data[SLOT_W-1:0];
			rd_ok_q  <= in_data[IN_RDOK_B];
			act_q    <= in_data[IN_ACT_B];
			seq_q    <= in_data[IN_SEQ_LO +: SEQ_W];
			gen_q    <= in_data[IN_GEN_LO +: GEN_W];
			seq_rd_q <= seq_mem[rd_idx];
			gen_rd_q <= gen_mem[rd_idx];
			lc_rd_q  <= lc_mem[rd_idx];
		end
		if (cmd.prep)
			tbase_q <= time_q - TIME_W'(death_ticks_q);
		if (cmd.eval && mem_wr) begin
			seq_mem[idx] <= seq_q;
			gen_mem[idx] <= gen_q;
			lc_mem[idx]  <= time_q;
		end
		if (cmd.eval) begin
			ev_q    <= ev_d;
			alive_q <= alive_d;
			eslot_q <= eslot_d;
			egen_q  <= egen_d;
		end
	end

	assign out_event = ev_q;
	assign out_data  = {(OUT_DATA_W - OUT_USED_W)'(0), egen_q, eslot_q, alive_q};

endmodule

// File: design/heartbeat_liveness_table.sv
// An accepted item passes through a table read (S_READ) and an evaluate step
// (S_EXEC) that waits while the previous result is still held; the result is
// registered. A new item is accepted only once the previous one is evaluated.
// Reset: arst_n clears the state machine, config registers, tick counter and
// per-slot seen/status flags immediately; no clearing pass is needed.
// ----------------------------------------------------------------------------
// heartbeat_liveness_table
// Per-slot peer liveness tracker driven by heartbeat, query and tick items.
// ----------------------------------------------------------------------------
module heartbeat_liveness_table
	import hlt_pkg::*;
#(
	parameter int MAX_SLOTS = DEFAULT_MAX_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// slot[7:0], read_ok[8], peer_active[9], sequence_req[73:10],
	// generation[105:74], zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// func[1:0]
	input  logic [FUNC_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// alive[0], event_slot[8:1], event_generation[40:9], zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	// event_res[1:0]
	output logic [EV_W-1:0]       m_tuser,
	input  logic                  cfg_wen,
	input  logic [CFG_A_W-1:0]    cfg_addr,
	input  logic [CFG_D_W-1:0]    cfg_wdata
);

	hlt_cmd_t cmd;

	hlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	hlt_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_func   (s_tuser),
		.in_data   (s_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.out_event (m_tuser),
		.out_data  (m_tdata)
	);

endmodule

// File: design/hlt_chk.sv
// ----------------------------------------------------------------------------
// hlt_chk
// Port-level checks for the heartbeat liveness table.
// ----------------------------------------------------------------------------
module hlt_chk
	import hlt_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [EV_W-1:0]       m_tuser
);

	// one item in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while previous one in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == EV_NONE)) |-> (m_tdata == '0))
		else $error("empty result carries data");

	a_alive_query: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != EV_QUERY)) |-> !m_tdata[0])
		else $error("alive flag outside a query reply");

endmodule

bind heartbeat_liveness_table hlt_chk u_hlt_chk (.*);

// File: bench/heartbeat_liveness_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heartbeat_liveness_table_test
// Self-checking bench for the peer liveness table. A short directed table
// covers reset defaults, field extremes and the ignore rules. Random
// heartbeat, query and tick traffic then runs under several register
// settings. Every item produces one result, which is checked against an
// in-bench model of the slot table.
// ----------------------------------------------------------------------------
module heartbeat_liveness_table_test;
	import hlt_pkg::*;

	localparam int TABLE_SLOTS = DEFAULT_MAX_SLOTS;
	localparam int PHASE_ITEMS = 175;
	localparam int PHASES = 6;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

	typedef struct packed {
		bit [FUNC_W-1:0] func;
		bit [SLOT_W-1:0] slot;
		bit              rd_ok;
		bit              act;
		bit [SEQ_W-1:0]  seq;
		bit [GEN_W-1:0]  gen;
	} beat_item_t;

	typedef struct packed {
		bit [EV_W-1:0]   kind;
		bit              alive;
		bit [SLOT_W-1:0] slot;
		bit [GEN_W-1:0]  gen;
	} event_t;

	typedef struct {
		bit                 is_cfg;
		bit [CFG_A_W-1:0]   cfg_idx;
		bit [CFG_D_W-1:0]   cfg_val;
		beat_item_t         item;
		bit                 typed;
		event_t             want;
	} stim_row_t;

	localparam event_t NO_EVENT = '0;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [FUNC_W-1:0]     s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [EV_W-1:0]       m_tuser;
	logic                  cfg_wen = 1'b0;
	logic [CFG_A_W-1:0]    cfg_addr = '0;
	logic [CFG_D_W-1:0]    cfg_wdata = '0;

	heartbeat_liveness_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_wen(cfg_wen),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// model of the slot table
	bit                tbl_seen[TABLE_SLOTS];
	bit [STAT_W-1:0]   tbl_status[TABLE_SLOTS];
	bit [SEQ_W-1:0]    tbl_seq[TABLE_SLOTS];
	bit [GEN_W-1:0]    tbl_gen[TABLE_SLOTS];
	bit [TIME_W-1:0]   tbl_changed[TABLE_SLOTS];
	bit                tbl_written[TABLE_SLOTS];
	bit [TIME_W-1:0]   tick_count = '0;
	bit [NCNT_W-1:0]   cfg_nodes = NODE_COUNT_RST;
	bit [OWN_W-1:0]    cfg_own = OWN_SLOT_RST;
	bit [DEATH_W-1:0]  cfg_window = DEATH_TICKS_RST;

	event_t      expected_events[$];
	stim_row_t   directed_rows[$];
	int unsigned fail_count = 0;
	int unsigned src_idle_pct = 21;
	int unsigned sink_idle_pct = 61;
	int unsigned hold_requests = 0;
	int unsigned holds_served = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;
	event_t      got_event;
	event_t      want_event;

	bit [NCNT_W-1:0]  phase_nodes[PHASES] = '{6'd32, 6'd2, 6'd17, 6'd32, 6'd8, 6'd0};
	bit [OWN_W-1:0]   phase_own[PHASES] = '{5'd0, 5'd31, 5'd3, 5'd31, 5'd7, 5'd0};
	bit [DEATH_W-1:0] phase_window[PHASES] = '{20'd1, 20'd5, 20'hFFFFF, 20'd12, 20'd3, 20'd0};

	function automatic bit in_table(bit [SLOT_W-1:0] s);
		return (s < cfg_nodes) && (s < TABLE_SLOTS);
	endfunction

	// wrap-safe: now strictly later than last change plus the window
	function automatic bit overdue(bit [4:0] i);
		bit [TIME_W-1:0] d;
		d = tick_count - (tbl_changed[i] + TIME_W'(cfg_window));
		return (d != 0) && !d[TIME_W-1];
	endfunction

	function automatic event_t liveness_predict(beat_item_t b);
		event_t r;
		bit [4:0] i;
		r = '0;
		i = b.slot[4:0];
		case (b.func)
			FUNC_OBS: begin
				if (in_table(b.slot) && b.slot != SLOT_W'(cfg_own) && b.rd_ok) begin
					if (!b.act || b.seq == 0) begin
						tbl_seen[i] = 1'b0;
					end else if (!tbl_seen[i] || b.seq != tbl_seq[i] || b.gen != tbl_gen[i]) begin
						tbl_seen[i] = 1'b1;
						tbl_seq[i] = b.seq;
						tbl_gen[i] = b.gen;
						tbl_written[i] = 1'b1;
						tbl_changed[i] = tick_count;
						if (tbl_status[i] != PST_ACTIVE) begin
							tbl_status[i] = PST_ACTIVE;
							r = '{EV_ALIVE, 1'b0, b.slot, b.gen};
						end
					end else if (tbl_status[i] == PST_ACTIVE && overdue(i)) begin
						tbl_status[i] = PST_DEAD;
						r = '{EV_DEAD, 1'b0, b.slot, tbl_gen[i]};
					end
				end
			end
			FUNC_QUERY: begin
				r.kind = EV_QUERY;
				r.slot = b.slot;
				if (in_table(b.slot)) begin
					if (b.slot == SLOT_W'(cfg_own)) begin
						r.alive = 1'b1;
					end else begin
						r.gen = tbl_gen[i];
						r.alive = tbl_status[i] == PST_ACTIVE && tbl_gen[i] == b.gen &&
							!overdue(i);
					end
				end
			end
			FUNC_TICK: begin
				tick_count = tick_count + 1;
			end
			default: ;
		endcase
		return r;
	endfunction

	// mostly well-formed heartbeats on live slots, with ticks, queries and noise
	function automatic beat_item_t next_beat();
		beat_item_t b;
		int unsigned lim;
		int unsigned pick;
		bit [SLOT_W-1:0] peer;
		lim = (cfg_nodes < TABLE_SLOTS) ? cfg_nodes : TABLE_SLOTS;
		b.func = FUNC_OBS;
		b.rd_ok = 1'b1;
		b.act = 1'b1;
		b.seq = {$urandom, $urandom};
		b.gen = $urandom;
		do begin
			peer = SLOT_W'($urandom_range(0, lim - 1));
		end while (peer == SLOT_W'(cfg_own));
		b.slot = peer;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			if (tbl_written[peer[4:0]] && $urandom_range(0, 1) == 1) begin
				b.seq = tbl_seq[peer[4:0]];
				b.gen = tbl_gen[peer[4:0]];
			end else if (tbl_written[peer[4:0]] && $urandom_range(0, 2) != 0) begin
				b.gen = tbl_gen[peer[4:0]];
			end
			if (b.seq == 0)
				b.seq = 1;
		end else if (pick < 65) begin
			b.func = FUNC_TICK;
		end else if (pick < 80) begin
			b.func = FUNC_QUERY;
			if ($urandom_range(0, 4) == 0)
				b.slot = SLOT_W'(cfg_own);
			if (tbl_written[b.slot[4:0]] && $urandom_range(0, 3) != 0)
				b.gen = tbl_gen[b.slot[4:0]];
		end else begin
			case ($urandom_range(0, 5))
				0: b.rd_ok = 1'b0;
				1: b.act = 1'b0;
				2: b.seq = '0;
				3: b.slot = SLOT_W'($urandom_range(lim, 255));
				4: begin
					b.func = FUNC_SPARE;
					b.slot = SLOT_W'($urandom_range(0, 255));
					b.rd_ok = 1'($urandom_range(0, 1));
					b.act = 1'($urandom_range(0, 1));
				end
				default: begin
					b.func = FUNC_QUERY;
					b.slot = SLOT_W'($urandom_range(lim, 255));
				end
			endcase
		end
		// never ask about a slot whose generation was never stored
		if (b.func == FUNC_QUERY && in_table(b.slot) && b.slot != SLOT_W'(cfg_own) &&
				!tbl_written[b.slot[4:0]])
			b.slot = SLOT_W'(cfg_own);
		return b;
	endfunction

	function automatic stim_row_t item_row(bit [FUNC_W-1:0] f, bit [SLOT_W-1:0] s, bit rd,
			bit act, bit [SEQ_W-1:0] seq, bit [GEN_W-1:0] g, bit typed, event_t want);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.cfg_idx = '0;
		r.cfg_val = '0;
		r.item = '{f, s, rd, act, seq, g};
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(bit [CFG_A_W-1:0] idx, bit [CFG_D_W-1:0] val);
		stim_row_t r;
		r.is_cfg = 1'b1;
		r.cfg_idx = idx;
		r.cfg_val = val;
		r.item = '0;
		r.typed = 1'b0;
		r.want = NO_EVENT;
		return r;
	endfunction

	task automatic offer(beat_item_t b, bit typed, event_t want);
		event_t predicted;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_DATA_W'({b.gen, b.seq, b.act, b.rd_ok, b.slot});
		s_tuser <= b.func;
		do @(posedge clk); while (!s_tready);
		predicted = liveness_predict(b);
		expected_events.push_back(typed ? want : predicted);
	endtask

	// stop offering and wait for every outstanding result, plus pipeline slack
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic program_reg(bit [CFG_A_W-1:0] idx, bit [CFG_D_W-1:0] val);
		drain();
		cfg_wen <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			CFG_NODE_COUNT:  cfg_nodes = val[NCNT_W-1:0];
			CFG_OWN_SLOT:    cfg_own = val[OWN_W-1:0];
			CFG_DEATH_TICKS: cfg_window = val[DEATH_W-1:0];
			default: ;
		endcase
	endtask

	// result side: check, then decide next ready (long hold when requested)
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			got_event = '{m_tuser, m_tdata[0], m_tdata[OUT_SLOT_LO +: SLOT_W],
				m_tdata[OUT_GEN_LO +: GEN_W]};
			if (expected_events.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected item: kind %0d alive %0d slot %0d gen %h",
						got_event.kind, got_event.alive, got_event.slot, got_event.gen);
			end else begin
				want_event = expected_events.pop_front();
				if (got_event.kind != want_event.kind || got_event.alive != want_event.alive ||
						got_event.slot != want_event.slot || got_event.gen != want_event.gen) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: expected kind %0d alive %0d slot %0d gen %h, got kind %0d alive %0d slot %0d gen %h",
							want_event.kind, want_event.alive, want_event.slot, want_event.gen,
							got_event.kind, got_event.alive, got_event.slot, got_event.gen);
				end
			end
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_requests != holds_served) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		// reset defaults: 32 slots, own slot 0, long death window
		directed_rows.push_back(item_row(FUNC_OBS, 8'd0, 1, 1, 64'd5, 32'd7, 1, NO_EVENT));
		directed_rows.push_back(item_row(FUNC_QUERY, 8'd0, 0, 0, 64'd0, '1, 1,
			'{EV_QUERY, 1'b1, 8'd0, 32'd0}));
		directed_rows.push_back(item_row(FUNC_QUERY, 8'd255, 1, 1, '1, '1, 1,
			'{EV_QUERY, 1'b0, 8'd255, 32'd0}));
		directed_rows.push_back(item_row(FUNC_SPARE, 8'd255, 1, 1, '1, '1, 1, NO_EVENT));
		directed_rows.push_back(item_row(FUNC_TICK, 8'd0, 0, 0, 64'd0, 32'd0, 1, NO_EVENT));
		directed_rows.push_back(item_row(FUNC_OBS, 8'd32, 1, 1, 64'd9, 32'd9, 1, NO_EVENT));
		directed_rows.push_back(item_row(FUNC_OBS, 8'd5, 0, 1, 64'd1, 32'd1, 1, NO_EVENT));
		directed_rows.push_back(item_row(FUNC_OBS, 8'd5, 1, 0, 64'd1, 32'd1, 1, NO_EVENT));
		directed_rows.push_back(item_row(FUNC_OBS, 8'd5, 1, 1, 64'd0, 32'd1, 1, NO_EVENT));
		directed_rows.push_back(cfg_row(CFG_DEATH_TICKS, 20'd2));
		directed_rows.push_back(item_row(FUNC_OBS, 8'd5, 1, 1, '1, '1, 1,
			'{EV_ALIVE, 1'b0, 8'd5, 32'hFFFF_FFFF}));
		directed_rows.push_back(item_row(FUNC_OBS, 8'd5, 1, 1, '1, '1, 0, NO_EVENT));
		directed_rows.push_back(item_row(FUNC_QUERY, 8'd5, 0, 0, 64'd0, '1, 0, NO_EVENT));
		directed_rows.push_back(item_row(FUNC_QUERY, 8'd5, 0, 0, 64'd0, 32'd0, 0, NO_EVENT));
		repeat (3)
			directed_rows.push_back(item_row(FUNC_TICK, 8'd0, 0, 0, 64'd0, 32'd0, 0, NO_EVENT));
		// window has run out: query fails, unchanged beat declares death
		directed_rows.push_back(item_row(FUNC_QUERY, 8'd5, 0, 0, 64'd0, '1, 0, NO_EVENT));
		directed_rows.push_back(item_row(FUNC_OBS, 8'd5, 1, 1, '1, '1, 0, NO_EVENT));
		directed_rows.push_back(item_row(FUNC_OBS, 8'd5, 1, 1, 64'd1, '1, 0, NO_EVENT));
		directed_rows.push_back(item_row(FUNC_OBS, 8'd5, 1, 1, 64'd2, '1, 0, NO_EVENT));
		directed_rows.push_back(item_row(FUNC_OBS, 8'd31, 1, 1, 64'd1, 32'd1, 0, NO_EVENT));
		directed_rows.push_back(cfg_row(CFG_NODE_COUNT, 20'd2));
		directed_rows.push_back(item_row(FUNC_QUERY, 8'd5, 0, 0, 64'd0, '1, 1,
			'{EV_QUERY, 1'b0, 8'd5, 32'd0}));
		directed_rows.push_back(item_row(FUNC_OBS, 8'd1, 1, 1, 64'd3, 32'd0, 1,
			'{EV_ALIVE, 1'b0, 8'd1, 32'd0}));
		directed_rows.push_back(cfg_row(CFG_OWN_SLOT, 20'd1));
		directed_rows.push_back(item_row(FUNC_QUERY, 8'd1, 0, 0, 64'd0, 32'd5, 1,
			'{EV_QUERY, 1'b1, 8'd1, 32'd0}));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			if (directed_rows[k].is_cfg)
				program_reg(directed_rows[k].cfg_idx, directed_rows[k].cfg_val);
			else
				offer(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1) begin
				phase_nodes[p] = NCNT_W'($urandom_range(2, 32));
				phase_own[p] = OWN_W'($urandom_range(0, 31));
				phase_window[p] = DEATH_W'($urandom_range(1, 30));
			end
			program_reg(CFG_NODE_COUNT, CFG_D_W'(phase_nodes[p]));
			program_reg(CFG_OWN_SLOT, CFG_D_W'(phase_own[p]));
			program_reg(CFG_DEATH_TICKS, phase_window[p]);
			src_idle_pct = (p < 2) ? 21 : (p < 4) ? 61 : 0;
			sink_idle_pct = (p < 2) ? 61 : (p < 4) ? 21 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// fill the block against a stalled result side
				if (p == 2 && n == 50)
					hold_requests++;
				if (p == 4 && n == 80)
					drain();
				offer(next_beat(), 1'b0, NO_EVENT);
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && expected_events.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: sim.f
design/hlt_pkg.sv
design/hlt_ctrl.sv
design/hlt_dp.sv
design/heartbeat_liveness_table.sv
design/hlt_chk.sv
bench/heartbeat_liveness_table_test.sv
